/* design/ffpa_pkg.sv */
// Shared package for the first-free page allocator.
// Holds field widths, opcode and status codes, register indexes and the
// command/status structs between controller and datapath. No dependencies.
package ffpa_pkg;

   // Parameter defaults
   localparam int MAX_PAGES_DEF  = 64;
   localparam int PAGE_BYTES_DEF = 4096;

   // Field widths
   localparam int ADDR_W    = 48;
   localparam int PAGES_W   = 7;
   localparam int OP_W      = 2;
   localparam int ST_W      = 2;
   localparam int CSR_IDX_W = 1;

   // Flag words in the bitmap RAM
   localparam int WORD_BITS = 32;
   localparam int BIT_W     = 5;

   // Opcodes
   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
   localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

   // Status codes
   localparam logic [ST_W-1:0] ST_OK        = 2'd0;
   localparam logic [ST_W-1:0] ST_NO_PAGE   = 2'd1;
   localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_PAGES = 1'b1;

   // Register reset values
   localparam logic [ADDR_W-1:0]  POOL_BASE_RST  = '0;
   localparam logic [PAGES_W-1:0] POOL_PAGES_RST = 7'd65;

   // Controller to datapath commands
   typedef struct packed {
      logic load_req;     // capture request, clear result
      logic rd_en;        // read one flag word
      logic rd_free;      // read address from the free index, else the scan word
      logic alloc_wr;     // write back word with the found page cleared
      logic free_wr;      // write back word with the freed page set
      logic wcnt_clr;     // restart scan at word zero
      logic wcnt_inc;     // advance scan to the next word
      logic div_start;    // capture the page offset for the lookup
      logic div_step;     // latch the page number of the offset
      logic calc_grant;   // form the granted address
      logic set_nopage;   // result status no free page
      logic set_notfound; // result status address not found
      logic init_flags;   // mark every page free
      logic out_load;     // move result into the output register
   } ffpa_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [OP_W-1:0] in_op;  // opcode at the request port
      logic cnt_zero;          // pool holds no data page
      logic alloc_hit;         // scanned word has a usable free page
      logic last_word;         // scanned word is the last inside the count
      logic free_hit;          // offset maps exactly onto a data page
   } ffpa_sts_type;

endpackage

/* design/ffpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffpa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/ffpa_datapath.sv */
// Datapath of the page allocator: pool registers, bitmap RAM with per-word
// valid bits, word scan, free-address page lookup and result registers.
// Depends on ffpa_pkg and ffpa_ram.
module ffpa_datapath #(
   parameter int MAX_PAGES  = ffpa_pkg::MAX_PAGES_DEF,
   parameter int PAGE_BYTES = ffpa_pkg::PAGE_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cfg_we,
   input  logic [ffpa_pkg::CSR_IDX_W-1:0]  cfg_index,
   input  logic [ffpa_pkg::ADDR_W-1:0]     cfg_data,
   input  logic [ffpa_pkg::OP_W-1:0]       in_op,
   input  logic [ffpa_pkg::ADDR_W-1:0]     in_addr,
   input  ffpa_pkg::ffpa_cmd_type          cmd,
   output ffpa_pkg::ffpa_sts_type          sts,
   output logic [ffpa_pkg::ADDR_W-1:0]     out_addr,
   output logic [ffpa_pkg::ST_W-1:0]       out_status
);
   import ffpa_pkg::*;

   localparam int NUM_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int IDX_W     = WADDR_W + BIT_W;
   localparam int CNT_W     = $clog2(MAX_PAGES + 1);
   localparam int CMP_W     = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
   localparam int LIMIT     = PAGE_BYTES * MAX_PAGES;
   localparam int REM_W     = $clog2(LIMIT + 1);
   localparam int PB_W      = $clog2(PAGE_BYTES + 1);
   localparam int Q_W       = CNT_W + 1;
   localparam int RCP_SH    = REM_W + $clog2(PAGE_BYTES);
   localparam int RCP_W     = REM_W + 2;
   localparam int QP_W      = REM_W + RCP_W;
   localparam int BACK_W    = PB_W + Q_W;
   localparam longint RCP_MUL = ((longint'(1) << RCP_SH) + longint'(PAGE_BYTES) - 1)
                                / longint'(PAGE_BYTES);

   // Pool registers
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [PAGES_W-1:0] pages_ff, pages_in;

   // Request and result
   logic [ADDR_W-1:0] addr_ff;
   logic [ADDR_W-1:0] grant_ff;
   logic [ST_W-1:0]   status_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;
   logic [ST_W-1:0]   rsp_st_ff;

   // Bitmap access
   logic [NUM_WORDS-1:0] valid_ff;
   logic [WADDR_W-1:0]   w_ff;
   logic [WADDR_W-1:0]   rd_word_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [WADDR_W-1:0]   rd_addr;
   logic [WORD_BITS-1:0] rd_data;
   logic [WORD_BITS-1:0] eff_word;
   logic [WORD_BITS-1:0] avail;
   logic [WORD_BITS-1:0] wr_data;
   logic [BIT_W-1:0]     hit_bit;
   logic                 wr_en;

   // Page lookup of a freed address
   logic [REM_W-1:0]  rem_ff;
   logic [Q_W-1:0]    q_ff;
   logic              off_ok_ff;
   logic [ADDR_W-1:0] off;
   logic [QP_W-1:0]   q_prod;
   logic [BACK_W-1:0] q_back;

   // Count and address helpers
   logic [PAGES_W-1:0] pages_m1;
   logic [CNT_W-1:0]   cnt;
   logic [CMP_W-1:0]   q_m1;
   logic [IDX_W-1:0]   free_idx;
   logic [IDX_W:0]     idx_p1;
   logic [PB_W+IDX_W:0] prod;

   // Register writes
   always_comb begin
      base_in  = base_ff;
      pages_in = pages_ff;
      if (cfg_we) begin
         unique case (cfg_index)
            CSR_POOL_BASE:  base_in  = cfg_data;
            CSR_POOL_PAGES: pages_in = cfg_data[PAGES_W-1:0];
            default:        base_in  = base_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= POOL_BASE_RST;
         pages_ff <= POOL_PAGES_RST;
      end else begin
         base_ff  <= base_in;
         pages_ff <= pages_in;
      end
   end

   // Data page count, saturated to the pool bound
   always_comb begin
      pages_m1 = (pages_ff == '0) ? '0 : pages_ff - 1'b1;
      if (int'(pages_m1) > MAX_PAGES) begin
         cnt = CNT_W'(MAX_PAGES);
      end else begin
         cnt = CNT_W'(pages_m1);
      end
   end

   // Scan the read word: mask pages beyond the count, find the lowest free one
   always_comb begin
      eff_word = valid_ff[rd_word_ff] ? rd_data : '1;
      for (int b = 0; b < WORD_BITS; b++) begin
         avail[b] = eff_word[b] && (CMP_W'({w_ff, BIT_W'(b)}) < CMP_W'(cnt));
      end
      hit_bit = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (avail[b]) begin
            hit_bit = BIT_W'(b);
         end
      end
   end

   // Free address lookup helpers
   assign off      = addr_ff - base_ff;
   assign q_prod   = QP_W'(rem_ff) * QP_W'(RCP_MUL);
   assign q_back   = BACK_W'(PAGE_BYTES) * BACK_W'(q_ff);
   assign q_m1     = CMP_W'(q_ff) - 1'b1;
   assign free_idx = q_m1[IDX_W-1:0];

   // RAM port control
   assign rd_addr = cmd.rd_free ? free_idx[IDX_W-1:BIT_W] : w_ff;
   assign wr_en   = cmd.alloc_wr || cmd.free_wr;
   assign wr_data = cmd.alloc_wr ? (eff_word & ~(WORD_BITS'(1) << hit_bit))
                                 : (eff_word | (WORD_BITS'(1) << idx_ff[BIT_W-1:0]));

   ffpa_ram #(
      .WIDTH(WORD_BITS),
      .DEPTH(NUM_WORDS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(rd_word_ff),
      .wr_data(wr_data),
      .rd_en  (cmd.rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Word valid bits: an unwritten word reads as all free
   always_ff @(posedge clock) begin
      if (reset || cmd.init_flags) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[rd_word_ff] <= 1'b1;
      end
   end

   // Scan pointer, read address and page index
   always_ff @(posedge clock) begin
      if (cmd.wcnt_clr) begin
         w_ff <= '0;
      end else if (cmd.wcnt_inc) begin
         w_ff <= w_ff + 1'b1;
      end
      if (cmd.rd_en) begin
         rd_word_ff <= rd_addr;
      end
      if (cmd.alloc_wr) begin
         idx_ff <= {w_ff, hit_bit};
      end else if (cmd.rd_en && cmd.rd_free) begin
         idx_ff <= free_idx;
      end
   end

   // Page number of the offset: capture the offset, then multiply by the
   // rounded-up reciprocal of the page size; exact for every offset in range
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff    <= off[REM_W-1:0];
         off_ok_ff <= (off <= ADDR_W'(LIMIT));
      end
      if (cmd.div_step) begin
         q_ff <= Q_W'(q_prod >> RCP_SH);
      end
   end

   // Granted address of the page at idx_ff
   assign idx_p1 = {1'b0, idx_ff} + 1'b1;
   assign prod   = PB_W'(PAGE_BYTES) * idx_p1;

   // Request capture and result
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         addr_ff   <= in_addr;
         grant_ff  <= '0;
         status_ff <= cmd.set_nopage ? ST_NO_PAGE : ST_OK;
      end else begin
         if (cmd.calc_grant) begin
            grant_ff <= base_ff + ADDR_W'(prod);
         end
         if (cmd.set_nopage) begin
            status_ff <= ST_NO_PAGE;
         end else if (cmd.set_notfound) begin
            status_ff <= ST_NOT_FOUND;
         end
      end
      if (cmd.out_load) begin
         rsp_addr_ff <= grant_ff;
         rsp_st_ff   <= status_ff;
      end
   end

   assign out_addr   = rsp_addr_ff;
   assign out_status = rsp_st_ff;

   // Status to the controller
   always_comb begin
      sts.in_op     = in_op;
      sts.cnt_zero  = (cnt == '0);
      sts.alloc_hit = |avail;
      sts.last_word = (CMP_W'({w_ff, BIT_W'(0)}) + CMP_W'(WORD_BITS)) >= CMP_W'(cnt);
      sts.free_hit  = off_ok_ff && (BACK_W'(rem_ff) == q_back) && (q_ff != '0) &&
                      (CMP_W'(q_ff) <= CMP_W'(cnt));
   end

   // The RAM is never read and written back in the same cycle
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.rd_en && (cmd.alloc_wr || cmd.free_wr)))
      else $error("bitmap read and write in one cycle");

   // A failed result never carries an address
   assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && (status_ff != ST_OK)) |-> (grant_ff == '0))
      else $error("failed result with nonzero address");

endmodule

/* design/ffpa_ctrl.sv */
// Controller of the page allocator: request sequencing state machine and
// output valid flag. Depends on ffpa_pkg.
module ffpa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  ffpa_pkg::ffpa_sts_type sts,
   output ffpa_pkg::ffpa_cmd_type cmd
);
   import ffpa_pkg::*;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_A_READ  = 4'd1;
   localparam logic [3:0] S_A_CHECK = 4'd2;
   localparam logic [3:0] S_A_ADDR  = 4'd3;
   localparam logic [3:0] S_F_START = 4'd4;
   localparam logic [3:0] S_F_DIV   = 4'd5;
   localparam logic [3:0] S_F_READ  = 4'd6;
   localparam logic [3:0] S_F_WRITE = 4'd7;
   localparam logic [3:0] S_RESP    = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               unique case (sts.in_op)
                  OP_ALLOC: begin
                     if (sts.cnt_zero) begin
                        cmd.set_nopage = 1'b1;
                        state_in       = S_RESP;
                     end else begin
                        cmd.wcnt_clr = 1'b1;
                        state_in     = S_A_READ;
                     end
                  end
                  OP_FREE: state_in = S_F_START;
                  OP_INIT: begin
                     cmd.init_flags = 1'b1;
                     state_in       = S_RESP;
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_A_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = S_A_CHECK;
         end
         S_A_CHECK: begin
            if (sts.alloc_hit) begin
               cmd.alloc_wr = 1'b1;
               state_in     = S_A_ADDR;
            end else if (sts.last_word) begin
               cmd.set_nopage = 1'b1;
               state_in       = S_RESP;
            end else begin
               cmd.wcnt_inc = 1'b1;
               state_in     = S_A_READ;
            end
         end
         S_A_ADDR: begin
            cmd.calc_grant = 1'b1;
            state_in       = S_RESP;
         end
         S_F_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_F_DIV;
         end
         S_F_DIV: begin
            cmd.div_step = 1'b1;
            state_in     = S_F_READ;
         end
         S_F_READ: begin
            if (sts.free_hit) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_free = 1'b1;
               state_in    = S_F_WRITE;
            end else begin
               cmd.set_notfound = 1'b1;
               state_in         = S_RESP;
            end
         end
         S_F_WRITE: begin
            cmd.free_wr = 1'b1;
            state_in    = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Output valid: set on load, drop after the transfer
   always_comb begin
      priority if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A result never overwrites one still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> out_free)
      else $error("result register overwritten");

   // Valid only rises out of the result state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_RESP))
      else $error("result valid raised outside result state");

endmodule

/* design/first_free_page_allocator.sv */
// Top level of the first-free page allocator: controller, datapath and
// configuration port. Depends on ffpa_pkg, ffpa_ctrl and ffpa_datapath.
//
//   Channel  Direction  Handshake               Payload
//   req_     in         req_tvalid/req_tready   tuser opcode, tdata page_address
//   rsp_     out        rsp_tvalid/rsp_tready   tuser status, tdata granted_address
//   csr_     in         csr_valid/csr_ready     csr_index, csr_data
//
// Allocate scans the 32-page bitmap words from word zero, one RAM read
// and check per word, then forms the granted address. Free does the offset
// subtract, reciprocal multiply for the page number, flag read and write
// back, and skips the flag read and write for an address that matches no page;
// init, opcode 3 and allocate from an empty pool go straight to the result.
// Reset is synchronous and marks every page free at once through per-word
// valid bits; no clearing pass. A waiting result does not block the next
// request transfer; the next result waits in its own state until taken.
module first_free_page_allocator #(
   parameter int MAX_PAGES  = ffpa_pkg::MAX_PAGES_DEF,
   parameter int PAGE_BYTES = ffpa_pkg::PAGE_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [ffpa_pkg::OP_W-1:0]      req_tuser,   // [1:0] opcode
   input  logic [ffpa_pkg::ADDR_W-1:0]    req_tdata,   // [47:0] page_address
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [ffpa_pkg::ST_W-1:0]      rsp_tuser,   // [1:0] status
   output logic [ffpa_pkg::ADDR_W-1:0]    rsp_tdata,   // [47:0] granted_address
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ffpa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ffpa_pkg::ADDR_W-1:0]    csr_data
);
   import ffpa_pkg::*;

   ffpa_cmd_type cmd;
   ffpa_sts_type sts;

   // Register writes are always taken
   assign csr_ready = 1'b1;

   ffpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ffpa_datapath #(
      .MAX_PAGES (MAX_PAGES),
      .PAGE_BYTES(PAGE_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg_we    (csr_valid && csr_ready),
      .cfg_index (csr_index),
      .cfg_data  (csr_data),
      .in_op     (req_tuser),
      .in_addr   (req_tdata),
      .cmd       (cmd),
      .sts       (sts),
      .out_addr  (rsp_tdata),
      .out_status(rsp_tuser)
   );

endmodule
